// ----- src/kmp_pkg.sv -----
// Package for the kana-to-mora parser: mora and token types, code point
// constants and the hiragana syllable table. No dependencies.
package kmp_pkg;

  // Kind of a mora as it leaves the block.
  typedef enum logic [2:0] {
    KIND_CV     = 3'd0,
    KIND_PAUSE  = 3'd1,
    KIND_SOKUON = 3'd2,
    KIND_LONG   = 3'd3,
    KIND_NASAL  = 3'd4,
    KIND_EMPTY  = 3'd5
  } kind_e;

  // Class of a code point as the front end sees it.
  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_PAUSE  = 2'd1,
    TOK_MORA   = 2'd2,
    TOK_SMALLY = 2'd3
  } tok_cls_e;

  localparam logic [4:0] CONS_NONE  = 5'd0;
  localparam logic [2:0] VOWEL_A    = 3'd0;
  localparam logic [2:0] VOWEL_I    = 3'd1;
  localparam logic [2:0] VOWEL_U    = 3'd2;
  localparam logic [2:0] VOWEL_O    = 3'd4;
  localparam logic [2:0] VOWEL_NONE = 3'd5;

  // Code points with a meaning of their own.
  localparam logic [20:0] CP_IDEO_COMMA = 21'h3001;
  localparam logic [20:0] CP_IDEO_STOP  = 21'h3002;
  localparam logic [20:0] CP_IDEO_SPACE = 21'h3000;
  localparam logic [20:0] CP_FW_COMMA   = 21'hFF0C;
  localparam logic [20:0] CP_COMMA      = 21'h00002C;
  localparam logic [20:0] CP_STOP       = 21'h00002E;
  localparam logic [20:0] CP_SPACE      = 21'h000020;
  localparam logic [20:0] CP_LF         = 21'h00000A;
  localparam logic [20:0] CP_CR         = 21'h00000D;
  localparam logic [20:0] CP_TAB        = 21'h000009;
  localparam logic [20:0] CP_SMALL_TSU  = 21'h3063;
  localparam logic [20:0] CP_KATA_TSU   = 21'h30C3;
  localparam logic [20:0] CP_LONG_MARK  = 21'h30FC;
  localparam logic [20:0] CP_HIRA_N     = 21'h3093;
  localparam logic [20:0] CP_KATA_N     = 21'h30F3;
  localparam logic [20:0] CP_SMALL_YA   = 21'h3083;
  localparam logic [20:0] CP_SMALL_YU   = 21'h3085;
  localparam logic [20:0] CP_SMALL_YO   = 21'h3087;

  // Syllable table covering the hiragana block from plain a upwards.
  localparam logic [20:0] TAB_BASE = 21'h3042;
  localparam int          TAB_LEN  = 81;
  localparam logic [20:0] TAB_LAST = 21'h3092;
  localparam logic [7:0]  SYL_NONE = 8'hFF;

  // Each entry holds the consonant in the upper five bits, the vowel below.
  localparam logic [7:0] SYL_TAB [TAB_LEN] = '{
    {5'd0, 3'd0}, SYL_NONE, {5'd0, 3'd1}, SYL_NONE, {5'd0, 3'd2}, SYL_NONE,
    {5'd0, 3'd3}, SYL_NONE, {5'd0, 3'd4},
    {5'd1, 3'd0}, {5'd2, 3'd0}, {5'd1, 3'd1}, {5'd2, 3'd1}, {5'd1, 3'd2},
    {5'd2, 3'd2}, {5'd1, 3'd3}, {5'd2, 3'd3}, {5'd1, 3'd4}, {5'd2, 3'd4},
    {5'd3, 3'd0}, {5'd5, 3'd0}, {5'd4, 3'd1}, {5'd6, 3'd1}, {5'd3, 3'd2},
    {5'd5, 3'd2}, {5'd3, 3'd3}, {5'd5, 3'd3}, {5'd3, 3'd4}, {5'd5, 3'd4},
    {5'd7, 3'd0}, {5'd10, 3'd0}, {5'd8, 3'd1}, {5'd6, 3'd1}, SYL_NONE,
    {5'd9, 3'd2}, {5'd5, 3'd2}, {5'd7, 3'd3}, {5'd10, 3'd3}, {5'd7, 3'd4},
    {5'd10, 3'd4},
    {5'd11, 3'd0}, {5'd11, 3'd1}, {5'd11, 3'd2}, {5'd11, 3'd3}, {5'd11, 3'd4},
    {5'd12, 3'd0}, {5'd15, 3'd0}, {5'd16, 3'd0}, {5'd13, 3'd1}, {5'd15, 3'd1},
    {5'd16, 3'd1}, {5'd14, 3'd2}, {5'd15, 3'd2}, {5'd16, 3'd2},
    {5'd12, 3'd3}, {5'd15, 3'd3}, {5'd16, 3'd3}, {5'd12, 3'd4}, {5'd15, 3'd4},
    {5'd16, 3'd4},
    {5'd17, 3'd0}, {5'd17, 3'd1}, {5'd17, 3'd2}, {5'd17, 3'd3}, {5'd17, 3'd4},
    SYL_NONE, {5'd18, 3'd0}, SYL_NONE, {5'd18, 3'd2}, SYL_NONE, {5'd18, 3'd4},
    {5'd19, 3'd0}, {5'd19, 3'd1}, {5'd19, 3'd2}, {5'd19, 3'd3}, {5'd19, 3'd4},
    SYL_NONE, {5'd20, 3'd0}, {5'd20, 3'd1}, {5'd20, 3'd3}, {5'd0, 3'd4}
  };

  // One classified code point, as it travels through the queue.
  typedef struct packed {
    tok_cls_e   cls;
    kind_e      kind;
    logic [4:0] cons;
    logic [2:0] vowel;
    logic       last;
  } tok_t;

  // The held mora.
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [4:0] cons;
    logic [2:0] vowel;
    logic       pal;
  } hold_t;

  // One result item.
  typedef struct packed {
    kind_e      kind;
    logic [4:0] cons;
    logic [2:0] vowel;
    logic       pal;
    logic       last;
  } mora_t;

  localparam hold_t HOLD_RESET = '{valid: 1'b0, kind: KIND_CV, cons: CONS_NONE,
                                   vowel: VOWEL_A, pal: 1'b0};

  localparam mora_t MORA_EMPTY = '{kind: KIND_EMPTY, cons: CONS_NONE,
                                   vowel: VOWEL_NONE, pal: 1'b0, last: 1'b1};

  // Queue full flag and push request as the front end sees them.
  typedef struct packed {
    logic full;
    logic push;
  } q_ctl_t;

endpackage

// ----- src/kmp_front.sv -----
// Front end of the kana-to-mora parser: accepts code points and classifies
// them into tokens for the queue. Depends on kmp_pkg.
module kmp_front (
  input  logic            cp_valid,
  output logic            cp_ready,
  input  logic [20:0]     code_point,
  input  logic            end_of_text,
  input  logic            q_full,
  output kmp_pkg::q_ctl_t q_ctl,
  output kmp_pkg::tok_t   tok
);

  logic [20:0] offset;
  logic [6:0]  tab_idx;
  logic [7:0]  syl;
  logic        in_tab;

  // A request is taken whenever the queue has room.
  assign cp_ready   = !q_full;
  assign q_ctl.full = q_full;
  assign q_ctl.push = cp_valid && !q_full;

  // Table lookup for the plain hiragana syllables.
  assign offset  = code_point - kmp_pkg::TAB_BASE;
  assign tab_idx = offset[6:0];
  assign in_tab  = (code_point >= kmp_pkg::TAB_BASE) && (code_point <= kmp_pkg::TAB_LAST);
  assign syl     = in_tab ? kmp_pkg::SYL_TAB[tab_idx] : kmp_pkg::SYL_NONE;

  // Classification, with punctuation taking precedence over everything else.
  always_comb begin
    tok.cls   = kmp_pkg::TOK_NONE;
    tok.kind  = kmp_pkg::KIND_CV;
    tok.cons  = kmp_pkg::CONS_NONE;
    tok.vowel = kmp_pkg::VOWEL_NONE;
    tok.last  = end_of_text;
    if (code_point == kmp_pkg::CP_IDEO_COMMA || code_point == kmp_pkg::CP_FW_COMMA ||
        code_point == kmp_pkg::CP_COMMA || code_point == kmp_pkg::CP_IDEO_STOP ||
        code_point == kmp_pkg::CP_STOP || code_point == kmp_pkg::CP_SPACE ||
        code_point == kmp_pkg::CP_IDEO_SPACE) begin
      tok.cls  = kmp_pkg::TOK_PAUSE;
      tok.kind = kmp_pkg::KIND_PAUSE;
    end else if (code_point == kmp_pkg::CP_LF || code_point == kmp_pkg::CP_CR ||
                 code_point == kmp_pkg::CP_TAB) begin
      tok.cls = kmp_pkg::TOK_NONE;
    end else if (code_point == kmp_pkg::CP_SMALL_TSU || code_point == kmp_pkg::CP_KATA_TSU) begin
      tok.cls  = kmp_pkg::TOK_MORA;
      tok.kind = kmp_pkg::KIND_SOKUON;
    end else if (code_point == kmp_pkg::CP_LONG_MARK) begin
      tok.cls  = kmp_pkg::TOK_MORA;
      tok.kind = kmp_pkg::KIND_LONG;
    end else if (code_point == kmp_pkg::CP_HIRA_N || code_point == kmp_pkg::CP_KATA_N) begin
      tok.cls  = kmp_pkg::TOK_MORA;
      tok.kind = kmp_pkg::KIND_NASAL;
    end else if (code_point == kmp_pkg::CP_SMALL_YA) begin
      tok.cls   = kmp_pkg::TOK_SMALLY;
      tok.vowel = kmp_pkg::VOWEL_A;
    end else if (code_point == kmp_pkg::CP_SMALL_YU) begin
      tok.cls   = kmp_pkg::TOK_SMALLY;
      tok.vowel = kmp_pkg::VOWEL_U;
    end else if (code_point == kmp_pkg::CP_SMALL_YO) begin
      tok.cls   = kmp_pkg::TOK_SMALLY;
      tok.vowel = kmp_pkg::VOWEL_O;
    end else if (syl != kmp_pkg::SYL_NONE) begin
      tok.cls   = kmp_pkg::TOK_MORA;
      tok.kind  = kmp_pkg::KIND_CV;
      tok.cons  = syl[7:3];
      tok.vowel = syl[2:0];
    end
  end

endmodule

// ----- src/kmp_queue.sv -----
// Token queue between the front and back ends of the kana-to-mora parser.
// Depends on kmp_pkg.
module kmp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  kmp_pkg::q_ctl_t q_ctl,
  input  kmp_pkg::tok_t   wr_tok,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output kmp_pkg::tok_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kmp_pkg::tok_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;
  logic             wr_en;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  assign wr_en      = q_ctl.push && !q_ctl.full;

  // Storage of the tokens themselves.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !do_pop) begin
        count <= count + 1'b1;
      end else if (!wr_en && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_ctl.push |-> !full) else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("fill count above the depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from an empty queue");
`endif

endmodule

// ----- src/kmp_back.sv -----
// Back end of the kana-to-mora parser: holds the newest mora, merges small
// ya/yu/yo, and drives the result register. Depends on kmp_pkg.
module kmp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  kmp_pkg::tok_t head,
  output logic          pop,
  output logic          mora_valid,
  input  logic          mora_ready,
  output kmp_pkg::mora_t mora
);

  kmp_pkg::hold_t held;
  kmp_pkg::hold_t held_next;
  kmp_pkg::hold_t nh;
  logic           half_done;
  logic           half_done_next;
  logic           can_load;
  logic           pause_ok;
  logic           merge;
  logic           fresh;
  logic           emit;
  kmp_pkg::mora_t emit_mora;
  kmp_pkg::mora_t held_mora;

  assign can_load = !mora_valid || mora_ready;

  // What the head token does to the held mora.
  always_comb begin
    pause_ok = held.valid && (held.kind != kmp_pkg::KIND_PAUSE);
    merge    = (head.cls == kmp_pkg::TOK_SMALLY) && held.valid &&
               (held.kind == kmp_pkg::KIND_CV) && (held.vowel == kmp_pkg::VOWEL_I) &&
               (held.cons != kmp_pkg::CONS_NONE);
    case (head.cls)
      kmp_pkg::TOK_PAUSE:  fresh = pause_ok;
      kmp_pkg::TOK_MORA:   fresh = 1'b1;
      kmp_pkg::TOK_SMALLY: fresh = 1'b0;
      default:             fresh = 1'b0;
    endcase
    nh = held;
    if (fresh) begin
      nh = '{valid: 1'b1, kind: head.kind, cons: head.cons, vowel: head.vowel, pal: 1'b0};
    end else if (merge) begin
      nh.vowel = head.vowel;
      nh.pal   = 1'b1;
    end
    held_mora = '{kind: held.kind, cons: held.cons, vowel: held.vowel, pal: held.pal,
                  last: 1'b0};
  end

  // Result selection and state update for the head token.
  always_comb begin
    emit           = 1'b0;
    emit_mora      = held_mora;
    pop            = 1'b0;
    held_next      = held;
    half_done_next = half_done;
    if (head_valid) begin
      if (half_done) begin
        // Second result of a fresh mora that also ends the text.
        emit           = 1'b1;
        emit_mora.last = 1'b1;
        if (can_load) begin
          pop            = 1'b1;
          held_next      = kmp_pkg::HOLD_RESET;
          half_done_next = 1'b0;
        end
      end else if (fresh && held.valid) begin
        emit = 1'b1;
        if (can_load) begin
          held_next = nh;
          if (head.last) begin
            half_done_next = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end else if (head.last) begin
        emit = 1'b1;
        if (nh.valid) begin
          emit_mora = '{kind: nh.kind, cons: nh.cons, vowel: nh.vowel, pal: nh.pal,
                        last: 1'b1};
        end else begin
          emit_mora = kmp_pkg::MORA_EMPTY;
        end
        if (can_load) begin
          pop       = 1'b1;
          held_next = kmp_pkg::HOLD_RESET;
        end
      end else begin
        pop       = 1'b1;
        held_next = nh;
      end
    end
  end

  // Held mora and the flag for a split two-result request.
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= kmp_pkg::HOLD_RESET;
      half_done <= 1'b0;
    end else begin
      held      <= held_next;
      half_done <= half_done_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mora_valid <= 1'b0;
    end else if (can_load) begin
      mora_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && emit) begin
      mora <= emit_mora;
    end
  end

`ifndef SYNTHESIS
  a_half_has_result: assert property (@(posedge clk) disable iff (rst)
    half_done |-> (mora_valid && head_valid && held.valid))
    else $error("split request without pending result or held mora");
  a_idle_not_palatal: assert property (@(posedge clk) disable iff (rst)
    !held.valid |-> !held.pal) else $error("palatal mark with nothing held");
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (mora_valid && mora.kind == kmp_pkg::KIND_EMPTY) |->
      (mora.last && mora.vowel == kmp_pkg::VOWEL_NONE))
    else $error("empty marker not final");
`endif

endmodule

// ----- src/kana_to_mora_parser_core.sv -----
// Kana-to-mora parser, top level: front end, token queue and back end.
// Depends on kmp_pkg, kmp_front, kmp_queue and kmp_back.
//
// Usage: code points arrive on the cp channel (cp_valid/cp_ready) with
// end_of_text set on the last one of a string. Morae leave on the mora
// channel (mora_valid/mora_ready), one per request, with last_of_text set
// on the final mora of the string; a string that yields no mora gives one
// empty-string marker instead.
// The newest mora is held back until the next mora, or the end of the text,
// releases it; the result is registered after the token queue. The block
// takes one code point per cycle while the queue has room. The back end
// produces at most one result per cycle, so a code point that ends the text
// and also releases a held mora occupies it for both results; the token
// queue (QUEUE_DEPTH entries) absorbs these and short receiver stalls.
// When the receiver stalls, the result register holds its mora, the back
// end waits, and cp_ready falls once the queue is full.
// Reset clears the queue, the held mora and the result register; the next
// string then starts fresh.
module kana_to_mora_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cp_valid,
  output logic        cp_ready,
  input  logic [20:0] code_point,
  input  logic        end_of_text,
  output logic        mora_valid,
  input  logic        mora_ready,
  output logic [2:0]  mora_kind,
  output logic [4:0]  consonant,
  output logic [2:0]  vowel,
  output logic        palatalized,
  output logic        last_of_text
);

  kmp_pkg::q_ctl_t q_ctl;
  kmp_pkg::tok_t   wr_tok;
  kmp_pkg::tok_t   head;
  kmp_pkg::mora_t  mora;
  logic            q_full;
  logic            head_valid;
  logic            pop;

  // Classification of incoming code points.
  kmp_front u_front (
    .cp_valid    (cp_valid),
    .cp_ready    (cp_ready),
    .code_point  (code_point),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_ctl       (q_ctl),
    .tok         (wr_tok)
  );

  // Queue between the two halves.
  kmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .q_ctl      (q_ctl),
    .wr_tok     (wr_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Mora assembly and output.
  kmp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .mora_valid (mora_valid),
    .mora_ready (mora_ready),
    .mora       (mora)
  );

  assign mora_kind    = mora.kind;
  assign consonant    = mora.cons;
  assign vowel        = mora.vowel;
  assign palatalized  = mora.pal;
  assign last_of_text = mora.last;

endmodule
